@@ rtl/vtpp_pkg.sv @@
// Package with shared types and constants for the video test pattern pixel generator.
`default_nettype none

package vtpp_pkg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_GREY_MODE    = 2'd2
    } cfg_index_t;

    localparam int CFG_ADDR_BITS     = 2;
    localparam int BAR_COUNT         = 8;
    localparam int BAR_BITS          = 3;
    localparam int RAMP_STEPS        = 16;
    localparam int RAMP_BITS         = 4;
    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;
    localparam logic [7:0] FULL_LEVEL = 8'd255;

    localparam rgb_t BAR_RGB [BAR_COUNT] = '{
        '{r: 8'd255, g: 8'd255, b: 8'd255},
        '{r: 8'd255, g: 8'd255, b: 8'd0},
        '{r: 8'd0,   g: 8'd255, b: 8'd255},
        '{r: 8'd0,   g: 8'd255, b: 8'd0},
        '{r: 8'd255, g: 8'd0,   b: 8'd255},
        '{r: 8'd255, g: 8'd0,   b: 8'd0},
        '{r: 8'd0,   g: 8'd0,   b: 8'd255},
        '{r: 8'd0,   g: 8'd0,   b: 8'd0}
    };

    // Grey staircase levels, bar * 255 / 7 truncated.
    localparam logic [7:0] STAIR_LEVEL [BAR_COUNT] = '{
        8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255
    };

endpackage

`default_nettype wire

@@ rtl/vtpp_limits.sv @@
// Configuration registers and the frame limits derived from them.
`default_nettype none

module vtpp_limits
    import vtpp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0]                  cfg_addr,
    input  wire logic [COORD_BITS-1:0]                     cfg_wdata,
    output logic                                           grey_mode,
    output logic [RAMP_STEPS-2:0][COORD_BITS+RAMP_BITS-1:0] col_thr,
    output logic [COORD_BITS-1:0]                          w_half,
    output logic [COORD_BITS-1:0]                          w_last,
    output logic                                           w_last_ok,
    output logic [COORD_BITS-1:0]                          h_half,
    output logic [COORD_BITS-1:0]                          h_last,
    output logic                                           h_last_ok,
    output logic [COORD_BITS-1:0]                          band_top,
    output logic [COORD_BITS-1:0]                          band_mid
);

    localparam int TW = COORD_BITS + RAMP_BITS;
    localparam int NB = COORD_BITS + 1;
    localparam int SH = NB + 2;
    localparam int RECIP3 = ((2 ** SH) + 2) / 3;
    localparam int RB = SH;
    localparam int PW = NB + RB;

    logic [COORD_BITS-1:0] frame_width_reg;
    logic [COORD_BITS-1:0] frame_height_reg;
    logic                  grey_mode_reg;

    logic [RAMP_STEPS-2:0][TW-1:0] col_thr_reg, col_thr_next;
    logic [COORD_BITS-1:0] w_half_reg, w_half_next;
    logic [COORD_BITS-1:0] w_last_reg, w_last_next;
    logic                  w_last_ok_reg, w_last_ok_next;
    logic [COORD_BITS-1:0] h_half_reg, h_half_next;
    logic [COORD_BITS-1:0] h_last_reg, h_last_next;
    logic                  h_last_ok_reg, h_last_ok_next;
    logic [COORD_BITS-1:0] band_top_reg, band_top_next;
    logic [COORD_BITS-1:0] band_mid_reg, band_mid_next;

    logic [NB-1:0]         h_twice;
    logic [COORD_BITS+1:0] h_thrice;
    logic [PW-1:0]         top_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= COORD_BITS'(RESET_FRAME_WIDTH);
            frame_height_reg <= COORD_BITS'(RESET_FRAME_HEIGHT);
            grey_mode_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                CFG_GREY_MODE:    grey_mode_reg    <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < RAMP_STEPS - 1; k++)
        begin
            col_thr_next[k] = TW'(k + 1) * TW'(frame_width_reg);
        end
        w_half_next    = frame_width_reg >> 1;
        w_last_next    = frame_width_reg - COORD_BITS'(1);
        w_last_ok_next = (frame_width_reg != '0);
        h_half_next    = frame_height_reg >> 1;
        h_last_next    = frame_height_reg - COORD_BITS'(1);
        h_last_ok_next = (frame_height_reg != '0);
        // Two thirds of the height by a reciprocal multiply, exact over the whole range.
        h_twice        = {frame_height_reg, 1'b0};
        top_prod       = PW'(h_twice) * PW'(RB'(RECIP3));
        band_top_next  = COORD_BITS'(top_prod >> SH);
        h_thrice       = (COORD_BITS+2)'(frame_height_reg) + (COORD_BITS+2)'(h_twice);
        band_mid_next  = COORD_BITS'(h_thrice >> 2);
    end

    always_ff @(posedge clk)
    begin
        col_thr_reg   <= col_thr_next;
        w_half_reg    <= w_half_next;
        w_last_reg    <= w_last_next;
        w_last_ok_reg <= w_last_ok_next;
        h_half_reg    <= h_half_next;
        h_last_reg    <= h_last_next;
        h_last_ok_reg <= h_last_ok_next;
        band_top_reg  <= band_top_next;
        band_mid_reg  <= band_mid_next;
    end

    assign grey_mode = grey_mode_reg;
    assign col_thr   = col_thr_reg;
    assign w_half    = w_half_reg;
    assign w_last    = w_last_reg;
    assign w_last_ok = w_last_ok_reg;
    assign h_half    = h_half_reg;
    assign h_last    = h_last_reg;
    assign h_last_ok = h_last_ok_reg;
    assign band_top  = band_top_reg;
    assign band_mid  = band_mid_reg;

endmodule

`default_nettype wire

@@ rtl/video_test_pattern_pixel.sv @@
// Top level of the color bar test pattern generator: one BGRA pixel per coordinate request.
// The block takes one coordinate request per clock while its output is taken and returns
// its pixel through three register stages (input capture, column and row compares
// against the frame limits, color selection into the output register). With the output
// taken every cycle it sustains one pixel per clock; a stalled output holds the pipeline
// without loss. A configuration write takes effect for requests accepted from the next
// clock on and may reach requests in flight. The top two thirds show eight bars (color or
// grey staircase), down to three quarters the same at half level, below that a 16-step grey
// ramp, with a white border and center crosshair on top; alpha is always 255.
`default_nettype none

module video_test_pattern_pixel
    import vtpp_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0]           cfg_addr,
    input  wire logic [COORD_BITS-1:0]              cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, zero fill to whole bytes.
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // Fields from bit 0 up: blue_byte, green_byte, red_byte, alpha_byte.
    output logic [31:0]                             m_axis_tdata
);

    localparam int TW = COORD_BITS + RAMP_BITS;

    logic                  grey_mode;
    logic [RAMP_STEPS-2:0][TW-1:0] col_thr;
    logic [COORD_BITS-1:0] w_half;
    logic [COORD_BITS-1:0] w_last;
    logic                  w_last_ok;
    logic [COORD_BITS-1:0] h_half;
    logic [COORD_BITS-1:0] h_last;
    logic                  h_last_ok;
    logic [COORD_BITS-1:0] band_top;
    logic [COORD_BITS-1:0] band_mid;

    vtpp_limits #(
        .COORD_BITS (COORD_BITS)
    ) u_limits (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .grey_mode (grey_mode),
        .col_thr   (col_thr),
        .w_half    (w_half),
        .w_last    (w_last),
        .w_last_ok (w_last_ok),
        .h_half    (h_half),
        .h_last    (h_last),
        .h_last_ok (h_last_ok),
        .band_top  (band_top),
        .band_mid  (band_mid)
    );

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_ready, s2_ready, s3_ready;
    logic s1_load, s2_load, s3_load;

    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;

    logic [RAMP_STEPS-2:0] s2_therm_reg, s2_therm_next;
    logic                  s2_upper_reg, s2_upper_next;
    logic                  s2_middle_reg, s2_middle_next;
    logic                  s2_white_reg, s2_white_next;

    rgb_t                  s3_rgb_reg, s3_rgb_next;

    logic [TW-1:0]         x_scaled;
    logic [RAMP_BITS-1:0]  step;
    logic [RAMP_BITS-1:0]  probe;
    logic [BAR_BITS-1:0]   bar;
    logic [7:0]            level;

    assign s3_ready = !s3_valid_reg || m_axis_tready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = s1_ready && s_axis_tvalid;
    assign s2_load  = s2_ready && s1_valid_reg;
    assign s3_load  = s3_ready && s2_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_ready ? s_axis_tvalid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg  : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg  : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_x_reg <= s_axis_tdata[COORD_BITS-1:0];
            s1_y_reg <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // Ramp step is the number of thresholds k*w that 16*x reaches.
    always_comb
    begin
        x_scaled = {s1_x_reg, RAMP_BITS'(0)};
        for (int k = 0; k < RAMP_STEPS - 1; k++)
        begin
            s2_therm_next[k] = (x_scaled >= col_thr[k]);
        end
        s2_upper_next  = (s1_y_reg < band_top);
        s2_middle_next = !s2_upper_next && (s1_y_reg < band_mid);
        s2_white_next  = (s1_x_reg == '0) || (s1_y_reg == '0)
                      || (w_last_ok && (s1_x_reg == w_last))
                      || (h_last_ok && (s1_y_reg == h_last))
                      || (s1_x_reg == w_half) || (s1_y_reg == h_half);
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_therm_reg  <= s2_therm_next;
            s2_upper_reg  <= s2_upper_next;
            s2_middle_reg <= s2_middle_next;
            s2_white_reg  <= s2_white_next;
        end
    end

    always_comb
    begin
        step = '0;
        for (int b = RAMP_BITS - 1; b >= 0; b--)
        begin
            probe = step | RAMP_BITS'(1 << b);
            if (s2_therm_reg[probe - RAMP_BITS'(1)])
            begin
                step = probe;
            end
        end
        bar   = step[RAMP_BITS-1:1];
        level = STAIR_LEVEL[bar];
        if (s2_upper_reg || s2_middle_reg)
        begin
            if (grey_mode)
            begin
                s3_rgb_next = '{r: level, g: level, b: level};
            end
            else
            begin
                s3_rgb_next = BAR_RGB[bar];
            end
            if (s2_middle_reg)
            begin
                s3_rgb_next.r = s3_rgb_next.r >> 1;
                s3_rgb_next.g = s3_rgb_next.g >> 1;
                s3_rgb_next.b = s3_rgb_next.b >> 1;
            end
        end
        else
        begin
            s3_rgb_next = '{r: {step, step}, g: {step, step}, b: {step, step}};
        end
        if (s2_white_reg)
        begin
            s3_rgb_next = '{r: FULL_LEVEL, g: FULL_LEVEL, b: FULL_LEVEL};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_rgb_reg <= s3_rgb_next;
        end
    end

    assign s_axis_tready = s1_ready;
    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = {FULL_LEVEL, s3_rgb_reg.r, s3_rgb_reg.g, s3_rgb_reg.b};

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> s1_valid_reg)
        else $error("accepted request did not enter the first stage");

    a_therm_shape : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ((s2_therm_reg & (s2_therm_reg + (RAMP_STEPS-1)'(1))) == '0))
        else $error("column compares are not a thermometer code");

    a_bands_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> !(s2_upper_reg && s2_middle_reg))
        else $error("row falls in two bands");

    a_stage_advance : assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s3_ready |=> m_axis_tvalid)
        else $error("second stage item did not reach the output");

    a_alpha_full : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:24] == FULL_LEVEL))
        else $error("alpha is not full");

endmodule

`default_nettype wire

@@ tb/tb_video_test_pattern_pixel.sv @@
// Self-checking testbench for the color bar test pattern pixel generator.
`timescale 1ns / 100ps

module tb_video_test_pattern_pixel;
    import vtpp_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int PIPE_LATENCY = 3;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_PIXELS = 100;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam logic [23:0] COLOR_BAR_RGB [8] = '{
        24'hFFFFFF, 24'hFFFF00, 24'h00FFFF, 24'h00FF00,
        24'hFF00FF, 24'hFF0000, 24'h0000FF, 24'h000000
    };

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bgra_t;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        bgra_t                 pixel;
    } pending_pixel_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0]      cfg_addr = '0;
    logic [COORD_BITS-1:0]         cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // Fields from bit 0 up: pixel_x, pixel_y.
    logic [TDATA_BITS-1:0]         s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // Fields from bit 0 up: blue_byte, green_byte, red_byte, alpha_byte.
    logic [31:0]                   m_axis_tdata;

    pending_pixel_t expected_pixels [$];
    int unsigned    frame_w = RESET_FRAME_WIDTH;
    int unsigned    frame_h = RESET_FRAME_HEIGHT;
    bit             grey_on = 1'b0;
    bit             gaps_on = 1'b1;
    int             fail_count = 0;
    int             pixels_checked = 0;
    int             settings_used = 1;

    video_test_pattern_pixel #(.COORD_BITS(COORD_BITS)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned scale_column(int unsigned x, int unsigned n);
        int unsigned v;
        if (frame_w == 0)
        begin
            return n - 1;
        end
        v = (x * n) / frame_w;
        return (v > n - 1) ? n - 1 : v;
    endfunction

    function automatic bgra_t predict_pixel(int unsigned x, int unsigned y);
        int unsigned bar;
        int unsigned level;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        bit          upper;
        bit          middle;
        bgra_t       p;
        bar = scale_column(x, 8);
        upper = y < (frame_h * 2) / 3;
        middle = !upper && (y < (frame_h * 3) / 4);
        if (upper || middle)
        begin
            if (grey_on)
            begin
                level = bar * 255 / 7;
                if (middle)
                begin
                    level = level / 2;
                end
                r = level;
                g = level;
                b = level;
            end
            else
            begin
                r = 32'(COLOR_BAR_RGB[bar][23:16]);
                g = 32'(COLOR_BAR_RGB[bar][15:8]);
                b = 32'(COLOR_BAR_RGB[bar][7:0]);
                if (middle)
                begin
                    r = r / 2;
                    g = g / 2;
                    b = b / 2;
                end
            end
        end
        else
        begin
            r = scale_column(x, 16) * 17;
            g = r;
            b = r;
        end
        if (x == 0 || y == 0 || x == frame_w - 1 || y == frame_h - 1 ||
            x == frame_w / 2 || y == frame_h / 2)
        begin
            r = 255;
            g = 255;
            b = 255;
        end
        p.alpha = 8'd255;
        p.red = r[7:0];
        p.green = g[7:0];
        p.blue = b[7:0];
        return p;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 96)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord(int unsigned span, bit is_row);
        int unsigned v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, 4095);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 0;
                    1: v = span - 1;
                    2: v = span / 2;
                    3: v = span;
                    default: v = 4095;
                endcase
            end
            3:
            begin
                if (is_row)
                begin
                    v = ($urandom_range(0, 1) ? (span * 2) / 3 : (span * 3) / 4)
                        + $urandom_range(0, 2) - 1;
                end
                else
                begin
                    v = (span * $urandom_range(1, 15)) / 16 + $urandom_range(0, 1);
                end
            end
            default: v = $urandom_range(0, span + span / 8);
        endcase
        return v[COORD_BITS-1:0];
    endfunction

    task automatic log_failure(string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // Called at a rising edge; returns at the edge where the request was accepted.
    task automatic send_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
        int unsigned    gap;
        pending_pixel_t entry;
        gap = (!gaps_on || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        do
        begin
            @(posedge clk);
        end
        while (s_axis_tready !== 1'b1);
        entry.x = x;
        entry.y = y;
        entry.pixel = predict_pixel(32'(x), 32'(y));
        expected_pixels.push_back(entry);
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [COORD_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        case (addr)
            CFG_FRAME_WIDTH:  frame_w = 32'(data);
            CFG_FRAME_HEIGHT: frame_h = 32'(data);
            CFG_GREY_MODE:    grey_on = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned w, int unsigned h, logic [COORD_BITS-1:0] grey);
        drain_pipeline();
        write_reg(CFG_FRAME_WIDTH, w[COORD_BITS-1:0]);
        write_reg(CFG_FRAME_HEIGHT, h[COORD_BITS-1:0]);
        write_reg(CFG_GREY_MODE, grey);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic test_reset_pattern();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd79, 12'd10);
        send_pixel(12'd80, 12'd10);
        send_pixel(12'd250, 12'd330);
        send_pixel(12'd400, 12'd319);
        send_pixel(12'd400, 12'd359);
        send_pixel(12'd400, 12'd360);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
    endtask

    task automatic test_grey_staircase();
        configure(640, 480, 12'd1);
        send_pixel(12'd570, 12'd100);
        send_pixel(12'd200, 12'd100);
        send_pixel(12'd500, 12'd340);
        send_pixel(12'd4000, 12'd200);
    endtask

    task automatic test_frame_extremes();
        configure(0, 0, 12'd0);
        drain_pipeline();
        write_reg(CFG_UNUSED, 12'hFFF);
        cfg_wr_en <= 1'b0;
        send_pixel(12'd5, 12'd9);
        send_pixel(12'd0, 12'd4095);
        configure(1, 1, 12'hFFE);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd3, 12'd3);
        configure(4095, 4095, 12'd1);
        send_pixel(12'd4094, 12'd4094);
        send_pixel(12'd2047, 12'd2047);
        send_pixel(12'd1000, 12'd2900);
        configure(2, 2, 12'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd2, 12'd3);
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin w = 4095; h = 4095; end
                1: begin w = 2; h = 2; end
                2: begin w = 0; h = $urandom_range(0, 4095); end
                default:
                begin
                    w = $urandom_range(0, 1) ? $urandom_range(2, 64) : $urandom_range(2, 4095);
                    h = $urandom_range(0, 1) ? $urandom_range(2, 64) : $urandom_range(2, 4095);
                end
            endcase
            configure(w, h, COORD_BITS'($urandom_range(0, 4095)));
            gaps_on = (phase % 4) != 3;
            repeat (PHASE_PIXELS)
            begin
                send_pixel(pick_coord(w, 1'b0), pick_coord(h, 1'b1));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        int unsigned hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                hold--;
            end
            else if (m_axis_tready && gaps_on)
            begin
                m_axis_tready <= 1'b0;
                hold = pick_gap() - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        bgra_t          got;
        pending_pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_pixels.size() == 0)
            begin
                log_failure($sformatf("pixel %h returned with no request outstanding", got));
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got.blue !== want.pixel.blue || got.green !== want.pixel.green ||
                    got.red !== want.pixel.red || got.alpha !== want.pixel.alpha)
                begin
                    log_failure($sformatf(
                        "x=%0d y=%0d expected b=%0d g=%0d r=%0d a=%0d, got b=%0d g=%0d r=%0d a=%0d",
                        want.x, want.y, want.pixel.blue, want.pixel.green, want.pixel.red,
                        want.pixel.alpha, got.blue, got.green, got.red, got.alpha));
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Timeout: no request moved for %0d cycles.", IDLE_LIMIT);
        $display("video_test_pattern_pixel verification failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_pattern();
        test_grey_staircase();
        test_frame_extremes();
        test_random_frames();
        drain_pipeline();
        $display("Checked %0d pixels across %0d frame settings, with color and grey bars,",
                 pixels_checked, settings_used);
        $display("zero, one and maximum frame sizes, and coordinates beyond the frame.");
        if (fail_count == 0)
        begin
            $display("video_test_pattern_pixel verification clean");
        end
        else
        begin
            $display("video_test_pattern_pixel verification failed");
        end
        $finish;
    end

endmodule
